// ----- rtl/core/mps_pkg.sv -----
// Shared types, constants and helpers for the motor status poller.
// Used by mps_frame_eval, motor_status_poller_core and its checker; no dependencies.
package mps_pkg;

    // Sizing
    localparam int RX_DEPTH   = 32;
    localparam int TIMER_BITS = 16;
    localparam int CFG_W      = 16;
    localparam int ADDR_W     = 8;
    localparam int CNT_W      = $clog2(RX_DEPTH + 1);
    localparam int TCMP_W     = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

    // Only the header bytes 0..6 of a frame are ever evaluated
    localparam int HDR_BYTES  = 7;
    localparam int HDR_IDX_W  = $clog2(HDR_BYTES);

    localparam int RAW_W      = 32;
    localparam int POS_W      = 42;
    localparam int SPD_W      = 17;
    localparam int DEG_W      = 9;
    localparam logic [DEG_W-1:0] DEG_PER_REV = 9'd360;

    // Frame codes and lengths
    localparam logic [7:0] CODE_TARGET  = 8'h33;
    localparam logic [7:0] CODE_SPEED   = 8'h35;
    localparam logic [7:0] CODE_CURRENT = 8'h36;
    localparam logic [CNT_W-1:0] LEN_MIN   = CNT_W'(2);
    localparam logic [CNT_W-1:0] LEN_POS   = CNT_W'(8);
    localparam logic [CNT_W-1:0] LEN_SPEED = CNT_W'(6);

    // Request types
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_BYTE  = 2'd1;
    localparam logic [1:0] REQ_ERROR = 2'd2;

    // Query kinds
    localparam logic [1:0] QK_TARGET  = 2'd0;
    localparam logic [1:0] QK_SPEED   = 2'd1;
    localparam logic [1:0] QK_CURRENT = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_PERIOD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPLY_GAP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPLY_TIMEOUT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOOT_DELAY    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDR   = 3'd4;

    // Reset values of the configuration registers
    localparam logic [CFG_W-1:0]  RST_QUERY_PERIOD  = 16'd80;
    localparam logic [CFG_W-1:0]  RST_REPLY_GAP     = 16'd5;
    localparam logic [CFG_W-1:0]  RST_REPLY_TIMEOUT = 16'd50;
    localparam logic [CFG_W-1:0]  RST_BOOT_DELAY    = 16'd500;
    localparam logic [ADDR_W-1:0] RST_DEVICE_ADDR   = 8'd1;

    // Result word, lowest field in the lowest bits
    localparam int OUT_TDATA_W  = 112;
    localparam int OUT_SEND_BIT = 0;
    localparam int OUT_KIND_LO  = 1;
    localparam int OUT_TAKEN_BIT = 3;
    localparam int OUT_READY_BIT = 105;
    localparam int OUT_WAIT_BIT  = 106;

    typedef struct packed {
        logic [4:0]             pad;
        logic                   awaiting_reply;
        logic                   is_ready;
        logic signed [SPD_W-1:0] speed_rpm;
        logic signed [POS_W-1:0] current_pos_q16;
        logic signed [POS_W-1:0] target_pos_q16;
        logic                   frame_taken;
        logic [1:0]             query_kind;
        logic                   query_send;
    } result_t;

    // Decoded frame: which status value to update and with what
    typedef struct packed {
        logic                    upd_target;
        logic                    upd_current;
        logic                    upd_speed;
        logic signed [POS_W-1:0] pos;
        logic signed [SPD_W-1:0] speed;
    } frame_upd_t;

    function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] t);
        return (&t) ? t : t + TIMER_BITS'(1);
    endfunction

    function automatic logic timer_met(input logic [TIMER_BITS-1:0] t,
                                       input logic [CFG_W-1:0] thr);
        return TCMP_W'(t) >= TCMP_W'(thr);
    endfunction

endpackage

// ----- rtl/core/motor_status_poller_core.sv -----
// Top level of the motor status poller: request handling, timers, query scheduler
// and a two-deep result buffer. Depends on mps_pkg and mps_frame_eval.
//
// Unless stalled, the block takes one request per clock and returns exactly one
// result per request. A request is a millisecond tick (s_tuser = 0), a received
// byte (s_tuser = 1, byte in s_tdata) or a receive error (s_tuser = 2); code 3
// is answered but changes nothing. All of the work for a request is done in the
// cycle it is accepted; the sustained rate is one request per clock while the
// sink keeps taking results. Results sit in an output register backed by a skid
// register: s_tready only drops when both hold results that the sink has not
// taken. On a tick the timers advance (saturating), the boot delay is checked,
// a frame is closed after reply_gap_ms idle ticks and decoded, an unanswered
// query is dropped after reply_timeout_ms, and then, if ready and no reply is
// pending, the next query (target position, speed, current position in turn)
// is issued once query_period_ms ticks have passed. Positions are reported in
// signed Q16 degrees (raw count times 360). The configuration port is always
// ready; write it only while no results are pending.
module motor_status_poller_core (
    input  logic                             aclk,
    input  logic                             aresetn,

    // Request channel
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] rx_byte
    input  logic [1:0]                       s_tuser,   // [1:0] req_type

    // Result channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] query_send, [2:1] query_kind, [3] frame_taken, [45:4] target_pos_q16,
    // [87:46] current_pos_q16, [104:88] speed_rpm, [105] is_ready,
    // [106] awaiting_reply, [111:107] zero
    output logic [mps_pkg::OUT_TDATA_W-1:0]  m_tdata,

    // Configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mps_pkg::CFG_W-1:0]        cfg_data
);

    // Configuration registers
    logic [mps_pkg::CFG_W-1:0]  period_reg, gap_reg, timeout_reg, boot_reg;
    logic [mps_pkg::ADDR_W-1:0] addr_reg;

    // Receive buffer: header bytes plus fill count
    logic [7:0]                 hdr_reg  [mps_pkg::HDR_BYTES];
    logic [7:0]                 hdr_next [mps_pkg::HDR_BYTES];
    logic [mps_pkg::CNT_W-1:0]  count_reg, count_next;

    // Timers and poller state
    logic [mps_pkg::TIMER_BITS-1:0] since_rx_reg,    since_rx_next;
    logic [mps_pkg::TIMER_BITS-1:0] since_query_reg, since_query_next;
    logic [mps_pkg::TIMER_BITS-1:0] since_wait_reg,  since_wait_next;
    logic [mps_pkg::TIMER_BITS-1:0] since_boot_reg,  since_boot_next;
    logic          ready_reg,   ready_next;
    logic          waiting_reg, waiting_next;
    logic [1:0]    next_q_reg,  next_q_next;

    // Last reported status
    logic signed [mps_pkg::POS_W-1:0] target_reg,  target_next;
    logic signed [mps_pkg::POS_W-1:0] current_reg, current_next;
    logic signed [mps_pkg::SPD_W-1:0] speed_reg,   speed_next;

    // Result buffer
    logic              out_valid_reg,  skid_valid_reg;
    mps_pkg::result_t  out_data_reg,   skid_data_reg;
    mps_pkg::result_t  res;

    mps_pkg::frame_upd_t upd;

    logic accept, pop;
    logic [mps_pkg::TIMER_BITS-1:0] rx_t, q_t, w_t, b_t;
    logic take, timeout, issue;
    logic [1:0] kind;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign accept    = s_tvalid && s_tready;
    assign pop       = out_valid_reg && m_tready;

    mps_frame_eval u_frame_eval (
        .hdr      (hdr_reg),
        .len      (count_reg),
        .dev_addr (addr_reg),
        .upd      (upd)
    );

    always_comb begin
        hdr_next         = hdr_reg;
        count_next       = count_reg;
        since_rx_next    = since_rx_reg;
        since_query_next = since_query_reg;
        since_wait_next  = since_wait_reg;
        since_boot_next  = since_boot_reg;
        ready_next       = ready_reg;
        waiting_next     = waiting_reg;
        next_q_next      = next_q_reg;
        target_next      = target_reg;
        current_next     = current_reg;
        speed_next       = speed_reg;

        // Tick path, evaluated in the order the poller defines
        rx_t    = mps_pkg::sat_inc(since_rx_reg);
        q_t     = mps_pkg::sat_inc(since_query_reg);
        w_t     = mps_pkg::sat_inc(since_wait_reg);
        b_t     = mps_pkg::sat_inc(since_boot_reg);
        take    = (count_reg != '0) && mps_pkg::timer_met(rx_t, gap_reg);
        timeout = waiting_reg && !take && mps_pkg::timer_met(w_t, timeout_reg);
        issue   = (ready_reg || mps_pkg::timer_met(b_t, boot_reg))
                  && (take || timeout || !waiting_reg)
                  && mps_pkg::timer_met(q_t, period_reg);
        kind    = (next_q_reg >= mps_pkg::QK_CURRENT) ? mps_pkg::QK_CURRENT : next_q_reg;

        unique case (s_tuser)
            mps_pkg::REQ_TICK: begin
                since_rx_next    = rx_t;
                since_query_next = issue ? '0 : q_t;
                since_wait_next  = issue ? '0 : w_t;
                since_boot_next  = b_t;
                ready_next       = ready_reg || mps_pkg::timer_met(b_t, boot_reg);
                if (take) begin
                    if (upd.upd_target)  target_next  = upd.pos;
                    if (upd.upd_current) current_next = upd.pos;
                    if (upd.upd_speed)   speed_next   = upd.speed;
                end
                if (take || timeout) begin
                    count_next   = '0;
                    waiting_next = 1'b0;
                end
                if (issue) begin
                    waiting_next = 1'b1;
                    next_q_next  = (kind == mps_pkg::QK_CURRENT) ? mps_pkg::QK_TARGET
                                                                 : kind + 2'd1;
                end
            end
            mps_pkg::REQ_BYTE: begin
                // Keep the header bytes; count the rest, empty on overflow
                if (count_reg < mps_pkg::CNT_W'(mps_pkg::RX_DEPTH)) begin
                    if (count_reg < mps_pkg::CNT_W'(mps_pkg::HDR_BYTES))
                        hdr_next[count_reg[mps_pkg::HDR_IDX_W-1:0]] = s_tdata;
                    count_next = count_reg + mps_pkg::CNT_W'(1);
                end else begin
                    count_next = '0;
                end
                since_rx_next = '0;
            end
            mps_pkg::REQ_ERROR: begin
                count_next = '0;
            end
            default: begin
            end
        endcase

        res                 = '0;
        res.query_send      = (s_tuser == mps_pkg::REQ_TICK) && issue;
        res.query_kind      = res.query_send ? kind : mps_pkg::QK_TARGET;
        res.frame_taken     = (s_tuser == mps_pkg::REQ_TICK) && take;
        res.target_pos_q16  = target_next;
        res.current_pos_q16 = current_next;
        res.speed_rpm       = speed_next;
        res.is_ready        = ready_next;
        res.awaiting_reply  = waiting_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg      <= mps_pkg::RST_QUERY_PERIOD;
            gap_reg         <= mps_pkg::RST_REPLY_GAP;
            timeout_reg     <= mps_pkg::RST_REPLY_TIMEOUT;
            boot_reg        <= mps_pkg::RST_BOOT_DELAY;
            addr_reg        <= mps_pkg::RST_DEVICE_ADDR;
            count_reg       <= '0;
            since_rx_reg    <= '0;
            since_query_reg <= '1;
            since_wait_reg  <= '0;
            since_boot_reg  <= '0;
            ready_reg       <= 1'b0;
            waiting_reg     <= 1'b0;
            next_q_reg      <= mps_pkg::QK_TARGET;
            target_reg      <= '0;
            current_reg     <= '0;
            speed_reg       <= '0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end else begin
            // Configuration writes; indexes past the list are dropped
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    mps_pkg::REG_QUERY_PERIOD:  period_reg  <= cfg_data;
                    mps_pkg::REG_REPLY_GAP:     gap_reg     <= cfg_data;
                    mps_pkg::REG_REPLY_TIMEOUT: timeout_reg <= cfg_data;
                    mps_pkg::REG_BOOT_DELAY:    boot_reg    <= cfg_data;
                    mps_pkg::REG_DEVICE_ADDR:   addr_reg    <= cfg_data[mps_pkg::ADDR_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (accept) begin
                count_reg       <= count_next;
                since_rx_reg    <= since_rx_next;
                since_query_reg <= since_query_next;
                since_wait_reg  <= since_wait_next;
                since_boot_reg  <= since_boot_next;
                ready_reg       <= ready_next;
                waiting_reg     <= waiting_next;
                next_q_reg      <= next_q_next;
                target_reg      <= target_next;
                current_reg     <= current_next;
                speed_reg       <= speed_next;
            end

            // Result buffer: drain skid first, else load output or skid
            if (skid_valid_reg) begin
                if (pop) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
            end else if (accept) begin
                if (!out_valid_reg || pop) out_valid_reg  <= 1'b1;
                else                       skid_valid_reg <= 1'b1;
            end else if (pop) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        if (accept) hdr_reg <= hdr_next;
        if (skid_valid_reg) begin
            if (pop) out_data_reg <= skid_data_reg;
        end else if (accept) begin
            if (!out_valid_reg || pop) out_data_reg  <= res;
            else                       skid_data_reg <= res;
        end
    end

endmodule

// ----- rtl/core/mps_frame_eval.sv -----
// Reply frame decoder for the motor status poller: checks address, code and
// length and converts the payload. Depends on mps_pkg.
module mps_frame_eval (
    input  logic [7:0]                    hdr [mps_pkg::HDR_BYTES],
    input  logic [mps_pkg::CNT_W-1:0]     len,
    input  logic [mps_pkg::ADDR_W-1:0]    dev_addr,
    output mps_pkg::frame_upd_t           upd
);

    logic [mps_pkg::RAW_W-1:0]   raw;
    logic [mps_pkg::POS_W-2:0]   mag;
    logic [mps_pkg::POS_W-1:0]   pos_mag;
    logic [mps_pkg::SPD_W-1:0]   spd_mag;
    logic                        neg;
    logic                        hit;

    always_comb begin
        raw     = {hdr[3], hdr[4], hdr[5], hdr[6]};
        // raw count to degrees, exact: 32 x 9 bits fits in 41 bits
        mag     = (mps_pkg::POS_W-1)'(raw) * (mps_pkg::POS_W-1)'(mps_pkg::DEG_PER_REV);
        pos_mag = {1'b0, mag};
        spd_mag = {1'b0, hdr[3], hdr[4]};
        neg     = (hdr[2] != 8'd0);
        hit     = (len >= mps_pkg::LEN_MIN) && (hdr[0] == dev_addr);

        upd.pos         = neg ? -pos_mag : pos_mag;
        upd.speed       = neg ? -spd_mag : spd_mag;
        upd.upd_target  = hit && (hdr[1] == mps_pkg::CODE_TARGET)  && (len == mps_pkg::LEN_POS);
        upd.upd_current = hit && (hdr[1] == mps_pkg::CODE_CURRENT) && (len == mps_pkg::LEN_POS);
        upd.upd_speed   = hit && (hdr[1] == mps_pkg::CODE_SPEED)   && (len == mps_pkg::LEN_SPEED);
    end

endmodule

// ----- rtl/core/motor_status_poller_core_checker.sv -----
// Port-level checker for motor_status_poller_core, bound to the top level.
// Depends on mps_pkg and motor_status_poller_core.
module motor_status_poller_core_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [mps_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // Hold a stalled result
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_kind_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[mps_pkg::OUT_SEND_BIT]
        |-> m_tdata[mps_pkg::OUT_KIND_LO +: 2] == mps_pkg::QK_TARGET)
        else $error("query kind set without a query");

    a_send_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[mps_pkg::OUT_SEND_BIT]
        |-> m_tdata[mps_pkg::OUT_WAIT_BIT] && m_tdata[mps_pkg::OUT_READY_BIT])
        else $error("query issued while not ready or not awaiting reply");

    a_one_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[mps_pkg::OUT_TAKEN_BIT] && m_tdata[mps_pkg::OUT_SEND_BIT]
        |-> m_tdata[mps_pkg::OUT_WAIT_BIT])
        else $error("frame closed and query issued but not awaiting reply");

endmodule

bind motor_status_poller_core motor_status_poller_core_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
